### design/mep_pkg.sv
package mep_pkg;

  localparam int NUM_ENCODERS = 3;

  // Input request codes
  localparam logic [1:0] REQ_RX_BYTE   = 2'd0;
  localparam logic [1:0] REQ_POLL      = 2'd1;
  localparam logic [1:0] REQ_CALIBRATE = 2'd2;
  localparam logic [1:0] REQ_PAUSE     = 2'd3;

  // Result kinds
  localparam logic [1:0] KIND_REQUEST    = 2'd0;
  localparam logic [1:0] KIND_READING    = 2'd1;
  localparam logic [1:0] KIND_REJECTED   = 2'd2;
  localparam logic [1:0] KIND_CALIBRATED = 2'd3;

  // Configuration register indexes
  localparam logic [1:0] CFG_INVERT_MASK  = 2'd0;
  localparam logic [1:0] CFG_INVERT_SPAN  = 2'd1;
  localparam logic [1:0] CFG_TWO_REG_MASK = 2'd2;

  localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
  localparam logic [15:0] SPAN_RESET        = 16'd4096;
  localparam logic [15:0] CRC_INIT          = 16'hFFFF;
  localparam logic [15:0] CRC_POLY          = 16'hA001;

  typedef logic [7:0][15:0] crc_table_t;

  // Modbus CRC-16 over one byte, reflected polynomial.
  function automatic logic [15:0] crc_feed(logic [15:0] crc, logic [7:0] data);
    logic [15:0] c;
    c = crc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // CRC of every possible request frame, indexed by {two registers, address}.
  function automatic crc_table_t poll_crc_table();
    crc_table_t tbl;
    logic [15:0] c;
    logic [2:0]  idx;
    for (int e = 0; e < 8; e++) begin
      idx = 3'(e);
      c = CRC_INIT;
      c = crc_feed(c, {6'd0, idx[1:0]});
      c = crc_feed(c, FUNC_READ_HOLDING);
      c = crc_feed(c, 8'h00);
      c = crc_feed(c, 8'h00);
      c = crc_feed(c, 8'h00);
      c = crc_feed(c, idx[2] ? 8'd2 : 8'd1);
      tbl[e] = c;
    end
    return tbl;
  endfunction

  localparam crc_table_t POLL_CRC = poll_crc_table();

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  id;
    logic        two_regs;
    logic [15:0] crc;
    logic [31:0] raw;
    logic [31:0] off;
    logic        all_ready;
  } result_t;

endpackage

### design/mep_in_if.sv
interface mep_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic        first_byte;
  logic [7:0]  rx_byte;
  logic [15:0] pause_ticks;

  modport source (output valid, req_type, first_byte, rx_byte, pause_ticks, input ready);
  modport sink (input valid, req_type, first_byte, rx_byte, pause_ticks, output ready);
endinterface

### design/mep_out_if.sv
interface mep_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [1:0]  encoder_id;
  logic [7:0]  tx_byte;
  logic [31:0] reading;
  logic [31:0] position;
  logic        all_ready;
  logic        last;

  modport source (output valid, kind, encoder_id, tx_byte, reading, position,
                  all_ready, last, input ready);
  modport sink (input valid, kind, encoder_id, tx_byte, reading, position,
                all_ready, last, output ready);
endinterface

### design/modbus_encoder_poller.sv
// Latency: an item's first result is presented the cycle after it is accepted.
// Throughput: one item per cycle; a poll that sends a request holds the result
// register for its eight request bytes, so the next item is taken with the eighth
// byte when results are taken at once.
// Any item waits while the receiver holds off a result that is still pending.
// Reset (rst, synchronous, active high) restores the configuration defaults,
// clears readings, offsets, poll address and pause, and waits for a first byte.
module modbus_encoder_poller
  import mep_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  mep_in_if.sink      req,
  mep_out_if.source   res
);

  logic [2:0]  invert_mask;
  logic [15:0] invert_span;
  logic [2:0]  two_register_mask;

  logic [1:0]  poll_address, poll_address_next;
  logic [15:0] pause_count, pause_count_next;
  logic [31:0] raw_readings [NUM_ENCODERS];
  logic [31:0] raw_next [NUM_ENCODERS];
  logic [31:0] zero_offsets [NUM_ENCODERS];
  logic [31:0] offsets_next [NUM_ENCODERS];
  logic [8:0]  rx_index, rx_index_next;
  logic [7:0]  rx_count, rx_count_next;
  logic [15:0] rx_crc, rx_crc_next;
  logic [31:0] rx_accum, rx_accum_next;
  logic        rx_discard, rx_discard_next;

  result_t     desc, desc_new;
  logic        desc_valid;
  logic [2:0]  beat;
  logic        desc_last;
  logic        emit;
  logic        fire;

  // Working values of the receive path
  logic [8:0]  idx0;
  logic [7:0]  cnt0;
  logic [15:0] crc1;
  logic [31:0] acc0;
  logic [8:0]  data_end;
  logic [1:0]  slot;
  logic [31:0] value;
  logic        reject;
  logic [1:0]  next_addr;
  logic        ready_all;

  assign desc_last = (desc.kind != KIND_REQUEST) || (beat == 3'd7);
  assign req.ready = !desc_valid || (res.ready && desc_last);
  assign fire      = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      invert_mask       <= 3'd4;
      invert_span       <= SPAN_RESET;
      two_register_mask <= 3'd3;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_INVERT_MASK:  invert_mask       <= cfg_data[2:0];
        CFG_INVERT_SPAN:  invert_span       <= cfg_data;
        CFG_TWO_REG_MASK: two_register_mask <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    poll_address_next = poll_address;
    pause_count_next  = pause_count;
    raw_next          = raw_readings;
    offsets_next      = zero_offsets;
    rx_index_next     = rx_index;
    rx_count_next     = rx_count;
    rx_crc_next       = rx_crc;
    rx_accum_next     = rx_accum;
    rx_discard_next   = rx_discard;
    emit              = 1'b0;
    reject            = 1'b0;
    desc_new          = '0;

    idx0     = req.first_byte ? 9'd0 : rx_index;
    cnt0     = req.first_byte ? 8'd0 : rx_count;
    acc0     = req.first_byte ? 32'd0 : rx_accum;
    crc1     = crc_feed(req.first_byte ? CRC_INIT : rx_crc, req.rx_byte);
    data_end = 9'd3 + {1'b0, cnt0};
    slot     = poll_address - 2'd1;
    value    = invert_mask[slot] ? ({16'd0, invert_span} - acc0) : acc0;
    next_addr = (32'(poll_address) >= NUM_ENCODERS) ? 2'd1 : poll_address + 2'd1;

    case (req.req_type)
      REQ_RX_BYTE: begin
        if (req.first_byte || !rx_discard) begin
          rx_discard_next = 1'b0;
          rx_count_next   = cnt0;
          rx_accum_next   = acc0;
          rx_crc_next     = crc1;
          rx_index_next   = idx0 + 9'd1;
          if (idx0 == 9'd0) begin
            reject = (poll_address == 2'd0) || (req.rx_byte != {6'd0, poll_address});
          end else if (idx0 == 9'd1) begin
            reject = (req.rx_byte != FUNC_READ_HOLDING);
          end else if (idx0 == 9'd2) begin
            rx_count_next = req.rx_byte;
          end else if (idx0 < data_end) begin
            rx_accum_next = {acc0[23:0], req.rx_byte};
          end else if (idx0 != data_end) begin
            // Final CRC byte: the remainder over the whole frame must be zero.
            if (crc1 != 16'd0 || poll_address == 2'd0) begin
              reject = 1'b1;
            end else begin
              rx_discard_next  = 1'b1;
              raw_next[slot]   = value;
              emit             = 1'b1;
              desc_new.kind    = KIND_READING;
              desc_new.id      = poll_address;
              desc_new.raw     = value;
              desc_new.off     = zero_offsets[slot];
            end
          end
          if (reject) begin
            rx_discard_next = 1'b1;
            emit            = 1'b1;
            desc_new.kind   = KIND_REJECTED;
            desc_new.id     = poll_address;
          end
        end
      end
      REQ_POLL: begin
        if (pause_count != 16'd0) begin
          pause_count_next = pause_count - 16'd1;
        end else begin
          poll_address_next = next_addr;
          rx_discard_next   = 1'b1;
          emit              = 1'b1;
          desc_new.kind     = KIND_REQUEST;
          desc_new.id       = next_addr;
          desc_new.two_regs = two_register_mask[next_addr - 2'd1];
          desc_new.crc      = POLL_CRC[{two_register_mask[next_addr - 2'd1], next_addr}];
        end
      end
      REQ_CALIBRATE: begin
        offsets_next  = raw_readings;
        emit          = 1'b1;
        desc_new.kind = KIND_CALIBRATED;
      end
      default: begin
        pause_count_next = req.pause_ticks;
      end
    endcase

    ready_all = 1'b1;
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      if (raw_next[k] == 32'd0) ready_all = 1'b0;
    end
    desc_new.all_ready = ready_all;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_address <= '0;
      pause_count  <= '0;
      rx_index     <= '0;
      rx_count     <= '0;
      rx_crc       <= CRC_INIT;
      rx_accum     <= '0;
      rx_discard   <= 1'b1;
      desc_valid   <= 1'b0;
      beat         <= '0;
      for (int k = 0; k < NUM_ENCODERS; k++) begin
        raw_readings[k] <= '0;
        zero_offsets[k] <= '0;
      end
    end else begin
      if (fire) begin
        poll_address <= poll_address_next;
        pause_count  <= pause_count_next;
        rx_index     <= rx_index_next;
        rx_count     <= rx_count_next;
        rx_crc       <= rx_crc_next;
        rx_accum     <= rx_accum_next;
        rx_discard   <= rx_discard_next;
        raw_readings <= raw_next;
        zero_offsets <= offsets_next;
      end
      if (fire && emit) begin
        desc_valid <= 1'b1;
        beat       <= '0;
      end else if (desc_valid && res.ready) begin
        if (desc_last) begin
          desc_valid <= 1'b0;
          beat       <= '0;
        end else begin
          beat <= beat + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire && emit) begin
      desc <= desc_new;
    end
  end

  always_comb begin
    res.tx_byte = 8'h00;
    if (desc.kind == KIND_REQUEST) begin
      case (beat)
        3'd0:    res.tx_byte = {6'd0, desc.id};
        3'd1:    res.tx_byte = FUNC_READ_HOLDING;
        3'd5:    res.tx_byte = desc.two_regs ? 8'd2 : 8'd1;
        3'd6:    res.tx_byte = desc.crc[7:0];
        3'd7:    res.tx_byte = desc.crc[15:8];
        default: res.tx_byte = 8'h00;
      endcase
    end
  end

  assign res.valid      = desc_valid;
  assign res.kind       = desc.kind;
  assign res.encoder_id = desc.id;
  assign res.reading    = desc.raw;
  // Only readings carry a nonzero raw value, so other kinds give position 0.
  assign res.position   = (desc.raw > desc.off) ? (desc.raw - desc.off) : 32'd0;
  assign res.all_ready  = desc.all_ready;
  assign res.last       = desc_last;

  a_request_holds_input: assert property (@(posedge clk) disable iff (rst)
    desc_valid && desc.kind == KIND_REQUEST && beat != 3'd7 |-> !req.ready)
    else $error("input accepted while request bytes are still pending");

  a_beat_only_in_request: assert property (@(posedge clk) disable iff (rst)
    beat != 3'd0 |-> desc_valid && desc.kind == KIND_REQUEST)
    else $error("byte counter running outside a request");

  a_poll_sends_request: assert property (@(posedge clk) disable iff (rst)
    fire && req.req_type == REQ_POLL && pause_count == 16'd0
      |=> desc_valid && rx_discard && desc.kind == KIND_REQUEST)
    else $error("poll tick without a pause did not start a request");

  a_address_in_range: assert property (@(posedge clk) disable iff (rst)
    32'(poll_address) <= NUM_ENCODERS)
    else $error("poll address beyond the encoder count");

endmodule

### sim/tb.sv
`timescale 1ns / 1ps
module tb;
  import mep_pkg::*;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int SETTLE_CYCLES  = 4;
  localparam int LONG_HOLD      = 80;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        first_byte;
    logic [7:0]  rx_byte;
    logic [15:0] pause_ticks;
  } poller_cmd_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [1:0]  encoder_id;
    logic [7:0]  tx_byte;
    logic [31:0] reading;
    logic [31:0] position;
    logic        all_ready;
    logic        last;
  } poller_result_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  mep_in_if  req();
  mep_out_if res();

  modbus_encoder_poller u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req),
    .res       (res)
  );

  // Predicted state of the poller.
  logic [2:0]  invert_mask;
  logic [15:0] invert_span;
  logic [2:0]  two_reg_mask;
  logic [1:0]  poll_addr;
  logic [15:0] pause_left;
  logic [31:0] enc_raw [NUM_ENCODERS];
  logic [31:0] enc_offset [NUM_ENCODERS];
  logic [31:0] enc_pos [NUM_ENCODERS];
  logic [8:0]  rx_pos;
  logic [7:0]  rx_len;
  logic [15:0] rx_crc;
  logic [31:0] rx_data;
  logic        rx_idle;

  poller_result_t expected_results [$];
  poller_result_t due;

  int  mismatches = 0;
  int  items_sent;
  int  stalled_cycles = 0;
  int  hold_request;
  int  hold_taken;
  int  hold_left;
  bit  quiet;

  always #10 clk = ~clk;

  function automatic logic [15:0] crc16_update(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) c = {1'b0, c[15:1]} ^ CRC_POLY;
      else c = {1'b0, c[15:1]};
    end
    return c;
  endfunction

  function automatic logic readings_complete();
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      if (enc_raw[k] == 32'd0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_result(logic [1:0] kind, logic [1:0] id, logic [7:0] tx,
                                      logic [31:0] raw, logic [31:0] pos, logic last);
    poller_result_t r;
    r.kind       = kind;
    r.encoder_id = id;
    r.tx_byte    = tx;
    r.reading    = raw;
    r.position   = pos;
    r.all_ready  = readings_complete();
    r.last       = last;
    expected_results.push_back(r);
  endfunction

  function automatic void reject_frame();
    rx_idle = 1'b1;
    push_result(KIND_REJECTED, poll_addr, 8'd0, 32'd0, 32'd0, 1'b1);
  endfunction

  // Returns 0 for a byte that the poller drops without looking at it.
  function automatic bit predict_item(poller_cmd_t c);
    logic [8:0]  i;
    logic [1:0]  slot;
    logic [31:0] v;
    logic [7:0]  frame [8];
    logic [15:0] crc;
    case (c.req_type)
      REQ_RX_BYTE: begin
        if (c.first_byte) begin
          rx_pos  = '0;
          rx_len  = '0;
          rx_crc  = CRC_INIT;
          rx_data = '0;
          rx_idle = 1'b0;
        end else if (rx_idle) begin
          return 1'b0;
        end
        i = rx_pos;
        rx_crc = crc16_update(rx_crc, c.rx_byte);
        rx_pos = rx_pos + 9'd1;
        if (i == 9'd0) begin
          if (poll_addr == 2'd0 || c.rx_byte != {6'd0, poll_addr}) reject_frame();
        end else if (i == 9'd1) begin
          if (c.rx_byte != FUNC_READ_HOLDING) reject_frame();
        end else if (i == 9'd2) begin
          rx_len = c.rx_byte;
        end else if (int'(i) < 3 + int'(rx_len)) begin
          rx_data = {rx_data[23:0], c.rx_byte};
        end else if (int'(i) > 3 + int'(rx_len)) begin
          // Last CRC byte: the remainder over the whole frame must be zero.
          if (rx_crc != 16'd0) begin
            reject_frame();
          end else begin
            rx_idle = 1'b1;
            slot = poll_addr - 2'd1;
            if (slot > 2'd2) begin
              reject_frame();
            end else begin
              v = rx_data;
              if (invert_mask[slot]) v = {16'd0, invert_span} - v;
              enc_raw[slot] = v;
              enc_pos[slot] = (v > enc_offset[slot]) ? v - enc_offset[slot] : 32'd0;
              push_result(KIND_READING, poll_addr, 8'd0, v, enc_pos[slot], 1'b1);
            end
          end
        end
      end
      REQ_POLL: begin
        if (pause_left != 16'd0) begin
          pause_left = pause_left - 16'd1;
        end else begin
          poll_addr = (int'(poll_addr) >= NUM_ENCODERS) ? 2'd1 : poll_addr + 2'd1;
          rx_idle = 1'b1;
          frame[0] = {6'd0, poll_addr};
          frame[1] = FUNC_READ_HOLDING;
          frame[2] = 8'd0;
          frame[3] = 8'd0;
          frame[4] = 8'd0;
          frame[5] = two_reg_mask[poll_addr - 2'd1] ? 8'd2 : 8'd1;
          crc = CRC_INIT;
          for (int k = 0; k < 6; k++) crc = crc16_update(crc, frame[k]);
          frame[6] = crc[7:0];
          frame[7] = crc[15:8];
          for (int k = 0; k < 8; k++) begin
            push_result(KIND_REQUEST, poll_addr, frame[k], 32'd0, 32'd0, k == 7);
          end
        end
      end
      REQ_CALIBRATE: begin
        for (int k = 0; k < NUM_ENCODERS; k++) enc_offset[k] = enc_raw[k];
        push_result(KIND_CALIBRATED, 2'd0, 8'd0, 32'd0, 32'd0, 1'b1);
      end
      default: pause_left = c.pause_ticks;
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(input poller_cmd_t c);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req.valid       <= 1'b1;
    req.req_type    <= c.req_type;
    req.first_byte  <= c.first_byte;
    req.rx_byte     <= c.rx_byte;
    req.pause_ticks <= c.pause_ticks;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    if (predict_item(c)) items_sent++;
  endtask

  task automatic send_byte(input logic first_flag, input logic [7:0] b);
    poller_cmd_t c;
    c.req_type    = REQ_RX_BYTE;
    c.first_byte  = first_flag;
    c.rx_byte     = b;
    c.pause_ticks = 16'($urandom);
    send_item(c);
  endtask

  task automatic send_op(input logic [1:0] op, input logic [15:0] ticks);
    poller_cmd_t c;
    c.req_type    = op;
    c.first_byte  = 1'($urandom);
    c.rx_byte     = 8'($urandom);
    c.pause_ticks = ticks;
    send_item(c);
  endtask

  // Sends a reply frame with random data; cut_at stops it after that many bytes.
  task automatic send_frame(input logic [7:0] addr, input logic [7:0] func, input int nbytes,
                            input bit bad_crc, input int cut_at);
    logic [7:0]  frame_bytes [$];
    logic [15:0] crc;
    frame_bytes = {addr, func, 8'(nbytes)};
    repeat (nbytes) frame_bytes.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame_bytes[k]) crc = crc16_update(crc, frame_bytes[k]);
    if (bad_crc) crc = crc ^ (16'd1 << $urandom_range(0, 15));
    frame_bytes.push_back(crc[7:0]);
    frame_bytes.push_back(crc[15:8]);
    for (int k = 0; k < frame_bytes.size() && k != cut_at; k++) begin
      send_byte(k == 0, frame_bytes[k]);
    end
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic configure(input logic [2:0] inv_mask, input logic [15:0] span,
                           input logic [2:0] two_mask);
    wait_idle();
    cfg_write <= 1'b1;
    cfg_index <= CFG_INVERT_MASK;
    cfg_data  <= {13'($urandom), inv_mask};
    @(posedge clk);
    cfg_index <= CFG_INVERT_SPAN;
    cfg_data  <= span;
    @(posedge clk);
    cfg_index <= CFG_TWO_REG_MASK;
    cfg_data  <= {13'($urandom), two_mask};
    @(posedge clk);
    cfg_write    <= 1'b0;
    invert_mask  = inv_mask;
    invert_span  = span;
    two_reg_mask = two_mask;
  endtask

  task automatic test_no_address();
    // Nothing has been polled yet, so the first frame is refused outright.
    send_frame(8'd1, FUNC_READ_HOLDING, 0, 1'b0, -1);
    send_byte(1'b0, 8'hFF);
    send_op(REQ_CALIBRATE, 16'($urandom));
  endtask

  task automatic test_pause();
    send_op(REQ_PAUSE, 16'hFFFF);
    send_op(REQ_PAUSE, 16'd2);
    repeat (3) send_op(REQ_POLL, 16'd0);
  endtask

  task automatic test_frames();
    send_frame(8'd1, FUNC_READ_HOLDING, 4, 1'b0, -1);
    send_op(REQ_POLL, 16'hFFFF);
    send_frame(8'd2, 8'hFF, 4, 1'b0, -1);
    send_op(REQ_POLL, 16'd0);
    send_frame(8'd3, FUNC_READ_HOLDING, 0, 1'b0, -1);
    send_op(REQ_CALIBRATE, 16'd0);
    send_op(REQ_POLL, 16'd0);
    // A frame cut short is restarted by the next first byte.
    send_frame(8'd1, FUNC_READ_HOLDING, 6, 1'b0, 5);
    send_frame(8'd1, FUNC_READ_HOLDING, 6, 1'b1, -1);
    send_op(REQ_POLL, 16'd0);
    send_frame(8'd0, FUNC_READ_HOLDING, 2, 1'b0, -1);
    // A new request drops the frame in progress; its tail is ignored.
    send_frame(8'd2, FUNC_READ_HOLDING, 2, 1'b0, 3);
    send_op(REQ_POLL, 16'd0);
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
    send_frame(8'd3, FUNC_READ_HOLDING, 2, 1'b0, -1);
  endtask

  task automatic test_backpressure();
    wait_idle();
    send_op(REQ_PAUSE, 16'd0);
    hold_request++;
    repeat (4) send_op(REQ_POLL, 16'($urandom));
  endtask

  task automatic send_reply_mix();
    int         mode;
    int         nbytes;
    logic [7:0] addr;
    addr   = {6'd0, poll_addr};
    nbytes = two_reg_mask[poll_addr - 2'd1] ? 4 : 2;
    mode   = $urandom_range(0, 99);
    if (mode < 70) begin
      send_frame(addr, FUNC_READ_HOLDING, nbytes, 1'b0, -1);
    end else if (mode < 76) begin
      send_frame(addr, FUNC_READ_HOLDING, $urandom_range(0, 8), 1'b0, -1);
    end else if (mode < 78) begin
      send_frame(addr, FUNC_READ_HOLDING, $urandom_range(9, 255), 1'b0, -1);
    end else if (mode < 84) begin
      send_frame(addr, FUNC_READ_HOLDING, nbytes, 1'b1, -1);
    end else if (mode < 88) begin
      send_frame(8'($urandom), FUNC_READ_HOLDING, nbytes, 1'b0, -1);
    end else if (mode < 92) begin
      send_frame(addr, 8'($urandom), nbytes, 1'b0, -1);
    end else if (mode < 96) begin
      send_frame(addr, FUNC_READ_HOLDING, nbytes, 1'b0, $urandom_range(1, nbytes + 3));
      send_frame(addr, FUNC_READ_HOLDING, nbytes, 1'b0, -1);
    end else begin
      send_frame(addr, FUNC_READ_HOLDING, nbytes, 1'b0, $urandom_range(1, nbytes + 3));
      send_op(REQ_POLL, 16'($urandom));
      repeat (3) send_byte(1'b0, 8'($urandom));
    end
  endtask

  task automatic test_random_traffic(input int n_items);
    int goal;
    int pick;
    goal = items_sent + n_items;
    while (items_sent < goal) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        if ($urandom_range(0, 9) == 0) send_op(REQ_PAUSE, 16'($urandom_range(0, 3)));
        while (pause_left != 16'd0) send_op(REQ_POLL, 16'($urandom));
        send_op(REQ_POLL, 16'($urandom));
        send_reply_mix();
      end else if (pick < 75) begin
        send_op(REQ_CALIBRATE, 16'($urandom));
      end else if (pick < 80) begin
        // A long pause is always replaced by a short one straight away.
        send_op(REQ_PAUSE, 16'($urandom));
        send_op(REQ_PAUSE, 16'($urandom_range(0, 2)));
      end else if (pick < 90) begin
        repeat ($urandom_range(1, 4)) send_byte(1'($urandom), 8'($urandom));
      end else begin
        send_frame({6'd0, 2'($urandom)}, FUNC_READ_HOLDING, $urandom_range(0, 4), 1'b0, -1);
      end
    end
  endtask

  // Result side: random stalls, plus a long hold when one is requested.
  always @(posedge clk) begin
    if (rst) begin
      res.ready <= 1'b0;
      hold_taken = 0;
      hold_left  = 0;
    end else if (hold_taken != hold_request) begin
      hold_taken = hold_request;
      hold_left  = LONG_HOLD - 1;
      res.ready <= 1'b0;
    end else if (hold_left != 0) begin
      res.ready <= 1'b0;
      hold_left--;
    end else if (!quiet && $urandom_range(0, 6) == 0) begin
      hold_left = $urandom_range(1, 5) - 1;
      res.ready <= 1'b0;
    end else begin
      res.ready <= 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (expected_results.size() == 0) begin
          $error("result with nothing expected: kind %0d id %0d", res.kind, res.encoder_id);
          mismatches++;
        end else begin
          due = expected_results.pop_front();
          check_field("kind", due.kind, res.kind);
          check_field("encoder_id", due.encoder_id, res.encoder_id);
          check_field("tx_byte", due.tx_byte, res.tx_byte);
          check_field("reading", due.reading, res.reading);
          check_field("position", due.position, res.position);
          check_field("all_ready", due.all_ready, res.all_ready);
          check_field("last", due.last, res.last);
        end
      end
      if ((res.valid && res.ready) || (req.valid && req.ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
        if (stalled_cycles >= WATCHDOG_LIMIT) begin
          $display("modbus_encoder_poller test failed");
          $finish;
        end
      end
    end
  end

  initial begin
    rst             = 1'b1;
    cfg_write       = 1'b0;
    cfg_index       = '0;
    cfg_data        = '0;
    req.valid       = 1'b0;
    req.req_type    = '0;
    req.first_byte  = 1'b0;
    req.rx_byte     = '0;
    req.pause_ticks = '0;
    quiet           = 1'b0;
    hold_request    = 0;
    items_sent      = 0;

    invert_mask  = 3'd4;
    invert_span  = SPAN_RESET;
    two_reg_mask = 3'd3;
    poll_addr    = '0;
    pause_left   = '0;
    for (int k = 0; k < NUM_ENCODERS; k++) begin
      enc_raw[k]    = '0;
      enc_offset[k] = '0;
      enc_pos[k]    = '0;
    end
    rx_pos  = '0;
    rx_len  = '0;
    rx_crc  = CRC_INIT;
    rx_data = '0;
    rx_idle = 1'b1;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    test_no_address();
    test_pause();
    test_frames();
    test_backpressure();
    configure(3'd0, 16'd0, 3'd0);
    test_random_traffic(120);
    configure(3'd7, 16'hFFFF, 3'd7);
    test_random_traffic(120);
    configure(3'($urandom), 16'($urandom), 3'($urandom));
    test_random_traffic(120);
    quiet = 1'b1;
    configure(3'($urandom), 16'($urandom), 3'($urandom));
    test_random_traffic(100);

    wait_idle();
    repeat (10) @(posedge clk);
    if (mismatches == 0) begin
      $display("modbus_encoder_poller test passed");
    end else begin
      $display("modbus_encoder_poller test failed");
    end
    $finish;
  end

endmodule
